// ----- hdl/gf2xb_pkg.sv -----
// ----------------------------------------------------------------------------
// gf2xb_pkg
// Shared constants and types of the GF(2) xor basis insert block.
// ----------------------------------------------------------------------------
package gf2xb_pkg;

  // vector geometry
  localparam int VectorWidth   = 64;
  localparam int LogicalPivots = 4;
  localparam int PosW          = $clog2(VectorWidth);

  // fixed field widths of the stream ports
  localparam int InDataW  = 64;
  localparam int PosOutW  = 6;
  localparam int RankW    = 3;
  localparam int OutDataW = 16;
  localparam int OutUsedW = 2 + PosOutW + RankW;

  // rank saturates at the top of its field
  localparam logic [RankW-1:0] RankMax = '1;

  // configuration port
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;
  localparam logic [0:0] RegRankLimit = 1'b0;
  localparam logic [RankW-1:0] RankLimitReset = 3'd2;

  // action codes carried on the input tuser
  localparam logic ActInsert = 1'b0;
  localparam logic ActClear  = 1'b1;

  // one result item
  typedef struct packed {
    logic [RankW-1:0]   count;
    logic [PosOutW-1:0] position;
    logic               new_pivot;
    logic               accepted;
  } result_t;

endpackage

// ----- hdl/gf2_xor_basis_insert.sv -----
// ----------------------------------------------------------------------------
// gf2_xor_basis_insert
// Incremental GF(2) row-echelon basis, one pivot row per leading-bit position.
// ----------------------------------------------------------------------------
// sequence: a clear item's result passes through the done state into the output
//   register; an insert walks the bit positions from the top down, one position
//   per cycle, through a single xor and row-memory read port, and its result
//   passes the same way, later while the previous result item still waits
// flow: one item at a time, a new one is taken only in the idle state
// reset: valid bits, rank and output register clear at once; limit register is 2
module gf2_xor_basis_insert import gf2xb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [63:0] vector_in
  input  logic                s_axis_tuser,   // [0] action
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [0] accepted, [1] new_pivot,
                                              // [7:2] pivot_position,
                                              // [10:8] logical_count, rest 0
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  typedef enum logic [1:0] {StIdle, StScan, StDone} state_e;

  state_e                 state_q;
  logic [PosW-1:0]        pos_q;
  logic [VectorWidth-1:0] vec_q;
  logic [VectorWidth-1:0] valid_q;
  logic [RankW-1:0]       rank_q;
  logic [RankW-1:0]       limit_q;
  result_t                res_q;
  result_t                out_q;
  logic                   out_valid_q;

  // row memory
  logic [VectorWidth-1:0] rows_mem [VectorWidth];
  logic [VectorWidth-1:0] rd_q;
  logic [PosW-1:0]        rd_addr;
  logic                   mem_we;

  logic             s_acc, m_acc, cfg_wr, out_free;
  logic             bit_set, have_row, store, last_pos, in_logical;
  logic [RankW-1:0] rank_nxt;

  // handshakes
  assign s_axis_tready = (state_q == StIdle);
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign m_acc    = m_axis_tvalid && m_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // configuration access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[ApbAddrW-1:2] == RegRankLimit) ?
                  ApbDataW'(limit_q) : '0;

  // decision on the current bit position
  assign bit_set    = vec_q[pos_q];
  assign have_row   = valid_q[pos_q];
  assign store      = bit_set && !have_row;
  assign last_pos   = (pos_q == '0);
  assign in_logical = int'(pos_q) < LogicalPivots;
  assign rank_nxt   = (in_logical && rank_q != RankMax) ? rank_q + 1'b1 : rank_q;

  // prefetch the row one position ahead of the scan
  assign rd_addr = (state_q == StScan) ? pos_q - 1'b1 : PosW'(VectorWidth - 1);
  assign mem_we  = (state_q == StScan) && store;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rows_mem[pos_q] <= vec_q;
    end
    rd_q <= rows_mem[rd_addr];
  end

  // sequencer, basis state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pos_q       <= '0;
      vec_q       <= '0;
      valid_q     <= '0;
      rank_q      <= '0;
      limit_q     <= RankLimitReset;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr && paddr[ApbAddrW-1:2] == RegRankLimit) begin
        limit_q <= pwdata[RankW-1:0];
      end
      // in the done state a taken result is replaced by the next one below
      if (m_acc && state_q != StDone) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (s_acc) begin
            if (s_axis_tuser == ActClear) begin
              valid_q <= '0;
              rank_q  <= '0;
              res_q   <= '{count: '0, position: '0, new_pivot: 1'b0, accepted: 1'b1};
              state_q <= StDone;
            end else begin
              vec_q   <= s_axis_tdata[VectorWidth-1:0];
              pos_q   <= PosW'(VectorWidth - 1);
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          if (bit_set && have_row) begin
            vec_q <= vec_q ^ rd_q;
          end
          if (store) begin
            valid_q[pos_q] <= 1'b1;
            rank_q         <= rank_nxt;
            res_q          <= '{count: rank_nxt, position: PosOutW'(pos_q),
                                new_pivot: 1'b1, accepted: (rank_nxt <= limit_q)};
            state_q        <= StDone;
          end else if (last_pos) begin
            res_q   <= '{count: rank_q, position: '0, new_pivot: 1'b0, accepted: 1'b1};
            state_q <= StDone;
          end else begin
            pos_q <= pos_q - 1'b1;
          end
        end
        StDone: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - OutUsedW)'(0), out_q};

endmodule

// ----- hdl/gf2xb_checker.sv -----
// ----------------------------------------------------------------------------
// gf2xb_checker
// Port-level checks of the GF(2) xor basis insert block.
// ----------------------------------------------------------------------------
module gf2xb_checker import gf2xb_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // no stored row means no position and an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |->
      m_axis_tdata[7:2] == '0 && m_axis_tdata[0])
    else $error("result without new row carries a position or is rejected");

  // logical rank never exceeds the number of logical pivots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> int'(m_axis_tdata[10:8]) <= LogicalPivots)
    else $error("logical count beyond the logical pivots");

  // padding bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:OutUsedW] == '0)
    else $error("result padding not zero");

endmodule

bind gf2_xor_basis_insert gf2xb_checker u_gf2xb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
